>>> rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // default handshake header limit in bytes
  localparam int HeaderLimitDef = 1024;

  localparam int MaxPayloadW = 21;
  localparam logic [MaxPayloadW-1:0] MaxPayloadRst = 21'd10240;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HANDSHAKE_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PAYLOAD    = 2'd1;

  // result event codes
  localparam logic [1:0] EV_PAYLOAD   = 2'd0;
  localparam logic [1:0] EV_HANDSHAKE = 2'd1;
  localparam logic [1:0] EV_EMPTY     = 2'd2;
  localparam logic [1:0] EV_CLOSE     = 2'd3;

  // frame parser phases
  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // header byte constants
  localparam logic [6:0] LEN_EXT16 = 7'h7E;
  localparam logic [6:0] LEN_EXT64 = 7'h7F;
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] payload;
    logic       last;
  } out_item_t;

  // per-request control from the top to a parser
  typedef struct packed {
    logic step;
    logic clr;
  } step_ctl_t;

  // parser result: hit marks a produced result item
  typedef struct packed {
    logic      hit;
    out_item_t item;
  } parse_res_t;

endpackage

>>> rtl/wsd_frame.sv
// ----------------------------------------------------------------------------
// wsd_frame
// Frame header parser, length clamp and payload unmasking.
// ----------------------------------------------------------------------------
module wsd_frame
  import wsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  step_ctl_t              ctl,
  input  logic [7:0]             data_byte,
  input  logic [MaxPayloadW-1:0] max_payload,
  output parse_res_t             res
);

  logic [2:0]             phase_r, phase_nxt;
  logic [3:0]             hcount_r, hcount_nxt;
  logic [7:0]             first_r, first_nxt;
  logic [63:0]            decl_r, decl_nxt;
  logic [MaxPayloadW-1:0] remain_r, remain_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             mphase_r, mphase_nxt;
  logic                   masked_r, masked_nxt;

  logic [63:0]            len_src;
  logic [MaxPayloadW-1:0] len_clamp;
  logic [MaxPayloadW-1:0] remain_dec;
  logic [3:0]             hcount_dec;
  logic [6:0]             len7;
  logic                   bad_hdr;

  always_comb begin
    phase_nxt  = phase_r;
    hcount_nxt = hcount_r;
    first_nxt  = first_r;
    decl_nxt   = decl_r;
    remain_nxt = remain_r;
    key_nxt    = key_r;
    mphase_nxt = mphase_r;
    masked_nxt = masked_r;
    res        = '0;

    len7       = data_byte[6:0];
    bad_hdr    = (first_r[6:4] != 3'b000) || !first_r[7] || (first_r[3:0] == OP_CONT);
    hcount_dec = hcount_r - 4'd1;
    remain_dec = remain_r - MaxPayloadW'(1);

    // length that the header ends with, by phase
    if (phase_r == PH_SECOND) begin
      len_src = {57'd0, len7};
    end else if (phase_r == PH_EXTLEN) begin
      len_src = {decl_r[55:0], data_byte};
    end else begin
      len_src = decl_r;
    end
    len_clamp = (len_src > {{(64-MaxPayloadW){1'b0}}, max_payload})
                ? max_payload : len_src[MaxPayloadW-1:0];

    case (phase_r)
      PH_FIRST: begin
        first_nxt = data_byte;
        phase_nxt = PH_SECOND;
      end
      PH_SECOND: begin
        if (bad_hdr) begin
          phase_nxt = PH_FIRST;
        end else if (first_r[3:0] == OP_CLOSE) begin
          phase_nxt            = PH_FIRST;
          res.hit              = 1'b1;
          res.item.event_res   = EV_CLOSE;
        end else begin
          masked_nxt = data_byte[7];
          key_nxt    = '0;
          mphase_nxt = 2'd0;
          decl_nxt   = '0;
          if (len7 inside {LEN_EXT16, LEN_EXT64}) begin
            hcount_nxt = (len7 == LEN_EXT16) ? 4'd2 : 4'd8;
            phase_nxt  = PH_EXTLEN;
          end else begin
            decl_nxt = len_src;
            if (data_byte[7]) begin
              hcount_nxt = 4'd4;
              phase_nxt  = PH_MASK;
            end else if (len_clamp == '0) begin
              phase_nxt     = PH_FIRST;
              res.hit       = 1'b1;
              res.item.event_res = EV_EMPTY;
              res.item.last = 1'b1;
            end else begin
              remain_nxt = len_clamp;
              phase_nxt  = PH_PAYLOAD;
            end
          end
        end
      end
      PH_EXTLEN: begin
        decl_nxt   = len_src;
        hcount_nxt = hcount_dec;
        if (hcount_dec == 4'd0) begin
          mphase_nxt = 2'd0;
          if (masked_r) begin
            hcount_nxt = 4'd4;
            phase_nxt  = PH_MASK;
          end else if (len_clamp == '0) begin
            phase_nxt     = PH_FIRST;
            res.hit       = 1'b1;
            res.item.event_res = EV_EMPTY;
            res.item.last = 1'b1;
          end else begin
            remain_nxt = len_clamp;
            phase_nxt  = PH_PAYLOAD;
          end
        end
      end
      PH_MASK: begin
        key_nxt    = {data_byte, key_r[31:8]};
        hcount_nxt = hcount_dec;
        if (hcount_dec == 4'd0) begin
          mphase_nxt = 2'd0;
          if (len_clamp == '0) begin
            phase_nxt     = PH_FIRST;
            res.hit       = 1'b1;
            res.item.event_res = EV_EMPTY;
            res.item.last = 1'b1;
          end else begin
            remain_nxt = len_clamp;
            phase_nxt  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        mphase_nxt       = mphase_r + 2'd1;
        remain_nxt       = remain_dec;
        res.hit          = 1'b1;
        res.item.event_res = EV_PAYLOAD;
        res.item.payload = masked_r ? (data_byte ^ key_r[8*mphase_r +: 8]) : data_byte;
        res.item.last    = (remain_dec == '0);
        if (remain_dec == '0) begin
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        phase_nxt = PH_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      phase_r  <= PH_FIRST;
      hcount_r <= '0;
      first_r  <= '0;
      decl_r   <= '0;
      remain_r <= '0;
      key_r    <= '0;
      mphase_r <= '0;
      masked_r <= 1'b0;
    end else if (ctl.step) begin
      phase_r  <= phase_nxt;
      hcount_r <= hcount_nxt;
      first_r  <= first_nxt;
      decl_r   <= decl_nxt;
      remain_r <= remain_nxt;
      key_r    <= key_nxt;
      mphase_r <= mphase_nxt;
      masked_r <= masked_nxt;
    end
  end

`ifndef SYNTHESIS
  // a final payload byte always sends the parser back to a new header
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && res.hit && res.item.last && res.item.event_res == EV_PAYLOAD
    |=> phase_r == PH_FIRST)
    else $error("frame parser did not restart after last payload byte");

  // payload phase never runs with nothing left to send
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remain_r != '0)
    else $error("payload phase with zero bytes remaining");
`endif

endmodule

>>> rtl/wsd_hshk.sv
// ----------------------------------------------------------------------------
// wsd_hshk
// Handshake pass-through with blank-line and header-limit packet end.
// ----------------------------------------------------------------------------
module wsd_hshk
  import wsd_pkg::*;
#(
  parameter int HEADER_LIMIT = HeaderLimitDef
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  step_ctl_t  ctl,
  input  logic [7:0] data_byte,
  output parse_res_t res
);

  localparam int CntW = $clog2(HEADER_LIMIT);

  logic [1:0]      crlf_r, crlf_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW:0]   count_inc;
  logic [7:0]      want;
  logic            done;

  always_comb begin
    want      = crlf_r[0] ? CHR_LF : CHR_CR;
    done      = 1'b0;
    count_inc = {1'b0, count_r} + (CntW+1)'(1);
    if (data_byte == want) begin
      if (crlf_r == 2'd3) begin
        done     = 1'b1;
        crlf_nxt = 2'd0;
      end else begin
        crlf_nxt = crlf_r + 2'd1;
      end
    end else begin
      crlf_nxt = (data_byte == CHR_CR) ? 2'd1 : 2'd0;
    end
    if (count_inc >= (CntW+1)'(HEADER_LIMIT)) begin
      done = 1'b1;
    end
    count_nxt = count_inc[CntW-1:0];
    if (done) begin
      count_nxt = '0;
      crlf_nxt  = 2'd0;
    end
    res.hit            = 1'b1;
    res.item.event_res = EV_HANDSHAKE;
    res.item.payload   = data_byte;
    res.item.last      = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      crlf_r  <= '0;
      count_r <= '0;
    end else if (ctl.step) begin
      crlf_r  <= crlf_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  // byte counter always wraps before the header limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} < (CntW+1)'(HEADER_LIMIT))
    else $error("handshake byte count reached header limit");

  // a packet end leaves no partial blank-line match behind
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && res.item.last |=> crlf_r == 2'd0 && count_r == '0)
    else $error("handshake state not cleared at packet end");
`endif

endmodule

>>> rtl/websocket_frame_deframer_core.sv
// a result appears on out_valid in the cycle after its request is accepted
// throughput: one request per cycle while in_ready is high; each byte is a single update of the parser
//   registers followed by one output register, which holds a result while out_ready is low
// reset (rst_n low, synchronous): parser state cleared, output emptied,
//   handshake_mode back to 0 and max_payload back to 10240
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side websocket deframer: frame header parsing, length clamp,
// payload unmasking, and handshake pass-through, one byte per request.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core
  import wsd_pkg::*;
#(
  parameter int HEADER_LIMIT = HeaderLimitDef
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input byte channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [MaxPayloadW-1:0] cfg_data
);

  logic                   hs_mode_r;
  logic [MaxPayloadW-1:0] max_payload_r;

  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic       in_acc;
  step_ctl_t  frm_ctl, hs_ctl;
  parse_res_t frm_res, hs_res, sel_res;

  // config writes are always taken; the user must only send them while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_mode_r     <= 1'b0;
      max_payload_r <= MaxPayloadRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HANDSHAKE_MODE: hs_mode_r     <= cfg_data[0];
        CFG_MAX_PAYLOAD:    max_payload_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // take a new request whenever the output register is empty or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // a connection start clears both parsers; a data byte steps only the active one
  always_comb begin
    frm_ctl.clr  = in_acc && in_data.kind;
    hs_ctl.clr   = in_acc && in_data.kind;
    frm_ctl.step = in_acc && !in_data.kind && !hs_mode_r;
    hs_ctl.step  = in_acc && !in_data.kind && hs_mode_r;
  end

  wsd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (frm_ctl),
    .data_byte   (in_data.data_byte),
    .max_payload (max_payload_r),
    .res         (frm_res)
  );

  wsd_hshk #(
    .HEADER_LIMIT (HEADER_LIMIT)
  ) u_hshk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hs_ctl),
    .data_byte (in_data.data_byte),
    .res       (hs_res)
  );

  // result of the parser that owns this byte
  assign sel_res = hs_mode_r ? hs_res : frm_res;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && !in_data.kind && sel_res.hit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sel_res.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a connection start never produces a result
  a_kind_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.kind |=> !out_valid_r)
    else $error("connection start produced a result");

  // a handshake-mode byte always yields a handshake result
  a_hs_result: assert property (@(posedge clk) disable iff (!rst_n)
    hs_ctl.step |=> out_valid_r && out_data_r.event_res == EV_HANDSHAKE)
    else $error("handshake byte lost");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the websocket deframer core: directed frames and
// header faults, then random frame and handshake traffic under changing
// settings, with every result checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import wsd_pkg::*;

  // unused register slots, written once to show they change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE3 = 2'd3;

  // first header byte pieces
  localparam logic [3:0] FIN_ONLY  = 4'b1000;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;

  localparam int          RandomItems = 1700;
  localparam int          CalmFrom    = 1550;
  localparam int unsigned RunLimitNs  = 4_000_000;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxW-1:0]     cfg_index = '0;
  logic [MaxPayloadW-1:0] cfg_data  = '0;

  websocket_frame_deframer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the core hangs on a handshake
  initial begin
    #(RunLimitNs);
    $display("websocket_frame_deframer_core verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // predictor state: register copies and the deframer's own view of the stream
  // --------------------------------------------------------------------------
  logic                   hs_mode  = 1'b0;
  logic [MaxPayloadW-1:0] max_pay  = MaxPayloadRst;

  logic [2:0]             ph       = PH_FIRST;
  logic [3:0]             hdr_left = '0;   // ext length or key bytes still due
  logic [7:0]             hdr0     = '0;   // first header byte
  logic [63:0]            decl_len = '0;   // declared length, kept whole
  logic [20:0]            pay_left = '0;
  logic [31:0]            key      = '0;   // first key byte in bits 7:0
  logic [1:0]             key_pos  = '0;
  logic                   key_on   = 1'b0;
  logic [1:0]             crlf_cnt = '0;
  int                     hs_cnt   = 0;

  out_item_t              due_events[$];   // results still owed by the core
  in_item_t               stream_q[$];     // bytes waiting for the driver
  int                     n_pushed   = 0;
  int                     n_accepted = 0;
  int                     n_errors   = 0;

  // idle controls, owned by the stimulus process
  bit                     src_idle_on = 1'b0;
  bit                     snk_idle_on = 1'b0;
  int                     src_gap     = 0;
  int                     snk_stall   = 0;

  out_item_t              fresh;
  out_item_t              want;

  function automatic out_item_t make_result(input logic [1:0] ev, input logic [7:0] v,
                                            input logic l);
    out_item_t r;
    r.event_res = ev;
    r.payload   = v;
    r.last      = l;
    return r;
  endfunction

  // header done: clamp the length, then either open the payload or report empty
  function automatic bit end_header(output out_item_t res);
    logic [63:0] cap;
    cap     = 64'(max_pay);
    key_pos = '0;
    res     = '0;
    if (decl_len > cap) cap = cap;
    else cap = decl_len;
    if (cap == 64'd0) begin
      ph  = PH_FIRST;
      res = make_result(EV_EMPTY, 8'h00, 1'b1);
      return 1'b1;
    end
    pay_left = cap[20:0];
    ph       = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // one accepted request in, at most one result out
  function automatic bit deframe_step(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    logic [7:0] v;
    logic       done;
    b    = it.data_byte;
    res  = '0;
    done = 1'b0;

    // connection start wipes both parsers, registers stay
    if (it.kind) begin
      ph       = PH_FIRST;
      hdr_left = '0;
      hdr0     = '0;
      decl_len = '0;
      pay_left = '0;
      key      = '0;
      key_pos  = '0;
      key_on   = 1'b0;
      crlf_cnt = '0;
      hs_cnt   = 0;
      return 1'b0;
    end

    // handshake pass-through: watch for the blank line or the size cap
    if (hs_mode) begin
      if (b == (crlf_cnt[0] ? CHR_LF : CHR_CR)) begin
        if (crlf_cnt == 2'd3) begin
          done     = 1'b1;
          crlf_cnt = '0;
        end else begin
          crlf_cnt = crlf_cnt + 2'd1;
        end
      end else begin
        crlf_cnt = (b == CHR_CR) ? 2'd1 : 2'd0;
      end
      hs_cnt = hs_cnt + 1;
      if (hs_cnt >= HeaderLimitDef) done = 1'b1;
      if (done) begin
        hs_cnt   = 0;
        crlf_cnt = '0;
      end
      res = make_result(EV_HANDSHAKE, b, done);
      return 1'b1;
    end

    case (ph)
      PH_FIRST: begin
        hdr0 = b;
        ph   = PH_SECOND;
        return 1'b0;
      end
      PH_SECOND: begin
        // reserved bits, missing fin or a continuation drop both bytes
        if (hdr0[6:4] != 3'd0 || !hdr0[7] || hdr0[3:0] == OP_CONT) begin
          ph = PH_FIRST;
          return 1'b0;
        end
        if (hdr0[3:0] == OP_CLOSE) begin
          ph  = PH_FIRST;
          res = make_result(EV_CLOSE, 8'h00, 1'b0);
          return 1'b1;
        end
        key_on   = b[7];
        key      = '0;
        key_pos  = '0;
        decl_len = '0;
        if (b[6:0] < LEN_EXT16) begin
          decl_len = 64'(b[6:0]);
        end else begin
          hdr_left = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
          ph       = PH_EXTLEN;
          return 1'b0;
        end
        if (key_on) begin
          hdr_left = 4'd4;
          ph       = PH_MASK;
          return 1'b0;
        end
        return end_header(res);
      end
      PH_EXTLEN: begin
        // big-endian extended length
        decl_len = {decl_len[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 4'd0) return 1'b0;
        if (key_on) begin
          hdr_left = 4'd4;
          ph       = PH_MASK;
          return 1'b0;
        end
        return end_header(res);
      end
      PH_MASK: begin
        key      = {b, key[31:8]};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 4'd0) return 1'b0;
        return end_header(res);
      end
      PH_PAYLOAD: begin
        v = b;
        if (key_on) v = v ^ key[key_pos*8 +: 8];
        key_pos  = key_pos + 2'd1;
        pay_left = pay_left - 21'd1;
        if (pay_left == 21'd0) ph = PH_FIRST;
        res = make_result(EV_PAYLOAD, v, pay_left == 21'd0);
        return 1'b1;
      end
      default: begin
        ph = PH_FIRST;
        return 1'b0;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // request driver: one byte per request from stream_q, random idle bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (src_gap != 0) begin
        src_gap = src_gap - 1;
        in_valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= stream_q.pop_front();
        if (src_idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (snk_stall != 0) begin
      snk_stall = snk_stall - 1;
      out_ready <= 1'b0;
    end else if (rst_n && snk_idle_on && $urandom_range(0, 9) == 0) begin
      snk_stall = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    n_errors = n_errors + 1;
  endtask

  // --------------------------------------------------------------------------
  // monitor: check results first, then fold in register writes and requests
  // taken at this edge; one block keeps the order fixed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          report_mismatch($sformatf("result ev=%0d byte=%0h last=%0d with nothing due",
                                    out_data.event_res, out_data.payload, out_data.last));
        end else begin
          want = due_events.pop_front();
          if (out_data.event_res !== want.event_res)
            report_mismatch($sformatf("event_res %0d, expected %0d",
                                      out_data.event_res, want.event_res));
          if (out_data.payload !== want.payload)
            report_mismatch($sformatf("payload %0h, expected %0h",
                                      out_data.payload, want.payload));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", out_data.last, want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HANDSHAKE_MODE: hs_mode = cfg_data[0];
          CFG_MAX_PAYLOAD:    max_pay = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        n_accepted = n_accepted + 1;
        if (deframe_step(in_data, fresh)) due_events.push_back(fresh);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.kind      = 1'b0;
    it.data_byte = b;
    stream_q.push_back(it);
    n_pushed = n_pushed + 1;
  endtask

  // new connection; the data byte is don't-care but still randomized
  task automatic send_restart();
    in_item_t it;
    it.kind      = 1'b1;
    it.data_byte = 8'($urandom_range(0, 255));
    stream_q.push_back(it);
    n_pushed = n_pushed + 1;
  endtask

  // register write, only issued while nothing is in flight
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MaxPayloadW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // all requests taken, all results back, then room for a silent byte in flight
  task automatic wait_drained();
    while (n_accepted != n_pushed || due_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one well-formed frame with random opcode, length encoding, mask and data
  task automatic queue_frame(input logic [20:0] lim);
    logic [3:0]  op;
    logic [6:0]  len7;
    logic [63:0] len;
    logic [63:0] eff;
    logic [31:0] kb;
    bit          masked;
    int          enc;
    int          pick;
    int          n;
    op     = 4'($urandom_range(1, 15));
    masked = 1'($urandom_range(0, 1));
    send_byte({FIN_ONLY, op});
    if (op == OP_CLOSE) begin
      send_byte({masked, 7'($urandom_range(0, 127))});
      return;
    end
    pick = $urandom_range(0, 9);
    enc  = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
    pick = $urandom_range(0, 5);
    case (enc)
      0: len = (pick < 3) ? 64'($urandom_range(0, 20)) : 64'($urandom_range(0, 125));
      1: len = (pick == 0) ? 64'hFFFF :
               (pick == 1) ? 64'($urandom_range(0, 65535)) : 64'($urandom_range(0, 40));
      default: begin
        // full-width lengths catch a compare cut down to 32 bits
        if (pick == 0)      len = '1;
        else if (pick == 1) len = {32'($urandom), 32'($urandom)};
        else if (pick == 2) len = {32'($urandom_range(1, 3)), 32'($urandom_range(0, 20))};
        else                len = 64'($urandom_range(0, 40));
      end
    endcase
    len7 = (enc == 0) ? len[6:0] : (enc == 1) ? LEN_EXT16 : LEN_EXT64;
    send_byte({masked, len7});
    if (enc == 1) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (enc == 2) begin
      for (int i = 7; i >= 0; i--) send_byte(len[i*8 +: 8]);
    end
    if (masked) begin
      kb = $urandom;
      for (int i = 0; i < 4; i++) send_byte(kb[i*8 +: 8]);
    end
    eff = (len > 64'(lim)) ? 64'(lim) : len;
    if (eff > 64'd200) begin
      // long body: send part of it, then drop the connection
      repeat (40) send_byte(8'($urandom_range(0, 255)));
      send_restart();
      return;
    end
    n = int'(eff);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
    // sometimes send the clamped-off tail too: it lands as header bytes
    if (eff < len && len <= 64'd200 && $urandom_range(0, 3) == 0) begin
      n = int'(len - eff);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
      send_restart();
    end
  endtask

  // two-byte header that must be dropped
  task automatic queue_bad_header();
    case ($urandom_range(0, 2))
      0:       send_byte({1'b1, 3'($urandom_range(1, 7)), 4'($urandom_range(0, 15))});
      1:       send_byte({1'b0, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))});
      default: send_byte({FIN_ONLY, OP_CONT});
    endcase
    send_byte(8'($urandom_range(0, 255)));
  endtask

  // http upgrade request: text lines, CR LF each, then the blank line
  task automatic queue_upgrade_request();
    int lines;
    int n;
    lines = $urandom_range(0, 4);
    repeat (lines) begin
      // near miss on the terminator: CR LF CR then something else
      if ($urandom_range(0, 5) == 0) send_byte(CHR_CR);
      n = $urandom_range(0, 12);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)));
        else send_byte(8'($urandom_range(32, 126)));
      end
      send_byte(CHR_CR);
      send_byte(CHR_LF);
    end
    send_byte(CHR_CR);
    send_byte(CHR_LF);
  endtask

  // --------------------------------------------------------------------------
  // stimulus: reset, directed cases, random phases, drain and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [MaxPayloadW-1:0] lim;
    int                     base;
    int                     pick;
    int                     steps;
    bit                     long_done;
    bit                     calm;
    lim       = MaxPayloadRst;
    long_done = 1'b0;
    calm      = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // spare indexes with all ones: mode or limit must not move
    write_reg(CFG_SPARE2, '1);
    write_reg(CFG_SPARE3, '1);

    // directed part, reset settings: frame mode, 10240 byte limit
    send_restart();
    send_byte({FIN_ONLY, OP_TEXT});      // unmasked, one byte, passes unchanged
    send_byte({1'b0, 7'd1});
    send_byte(8'hFF);
    send_byte({FIN_ONLY, OP_BINARY});    // masked, two bytes
    send_byte({1'b1, 7'd2});
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte({FIN_ONLY, OP_CLOSE});     // close request
    send_byte({1'b1, 7'd0});
    send_byte({FIN_ONLY, OP_TEXT});      // empty frame
    send_byte(8'h00);
    send_byte({4'b1111, OP_TEXT});       // reserved bits set
    send_byte(8'h05);
    send_byte({4'b0000, OP_TEXT});       // fin clear
    send_byte(8'h05);
    send_byte({FIN_ONLY, OP_CONT});      // continuation opcode
    send_byte(8'h05);
    send_byte({FIN_ONLY, OP_BINARY});    // parser back in sync after the drops
    send_byte(8'h00);

    base = n_pushed;
    while (n_pushed - base < RandomItems) begin
      wait_drained();
      calm        = (n_pushed - base) >= CalmFrom;
      src_idle_on = !calm && $urandom_range(0, 2) != 0;
      snk_idle_on = !calm && $urandom_range(0, 2) != 0;

      if (!long_done && n_pushed - base >= 300) begin
        // a request with no blank line runs into the header size cap
        write_reg(CFG_HANDSHAKE_MODE, 21'd1);
        repeat (HeaderLimitDef + 6) send_byte(8'($urandom_range(32, 126)));
        long_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_HANDSHAKE_MODE, 21'd1);
        if ($urandom_range(0, 2) == 0) write_reg(CFG_MAX_PAYLOAD, lim);
        if ($urandom_range(0, 2) == 0) send_restart();
        steps = $urandom_range(1, 4);
        repeat (steps) queue_upgrade_request();
      end else begin
        // frame phase; mostly small limits, extremes now and then
        pick = $urandom_range(0, 11);
        case (pick)
          0:       lim = '0;
          1:       lim = 21'd1;
          2:       lim = 21'd1048576;
          3:       lim = '1;
          4:       lim = 21'($urandom_range(100, 70000));
          default: lim = 21'($urandom_range(2, 48));
        endcase
        write_reg(CFG_HANDSHAKE_MODE, 21'd0);
        write_reg(CFG_MAX_PAYLOAD, lim);
        if ($urandom_range(0, 1) == 0) send_restart();
        steps = $urandom_range(4, 20);
        repeat (steps) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            queue_bad_header();
          end else if (pick == 1) begin
            send_restart();
          end else if (pick == 2) begin
            // stray bytes knock the framing off until the next connection
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0) send_restart();
          end else begin
            queue_frame(lim);
          end
        end
        // leave a header half read so the mode switch has state to keep
        if ($urandom_range(0, 3) == 0) begin
          send_byte({FIN_ONLY, OP_BINARY});
          if ($urandom_range(0, 1) == 0) send_byte({1'b1, 7'd3});
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (n_errors == 0) begin
      $display("websocket_frame_deframer_core verification clean");
    end else begin
      $display("websocket_frame_deframer_core verification failed");
    end
    $finish;
  end

endmodule
